### hw/rtl/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int DATA_W             = 32;
    localparam int GAIN_W             = 25;
    localparam int CFG_IDX_W          = 2;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd1678;
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd3355443;
    localparam logic [DATA_W-1:0] START_COVARIANCE_RST  = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_NOISE     = 2'd0,
        CFG_MEASUREMENT_NOISE = 2'd1,
        CFG_START_COVARIANCE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_INIT,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_UPD,
        ST_WB
    } t_state;

    typedef struct packed {
        logic load;
        logic pred;
        logic init;
        logic div_step;
        logic mul_est;
        logic mul_cov;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

### hw/rtl/skf_dp.sv
// Datapath of the scalar Kalman filter: state, bit-serial gain divider, shared multiplier.
module skf_dp import skf_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_restart,
    input  logic [DATA_W-1:0]        i_process_noise,
    input  logic [DATA_W-1:0]        i_measurement_noise,
    input  logic [DATA_W-1:0]        i_start_covariance,
    output logic [DATA_W-1:0]        o_estimate,
    output logic [DATA_W-1:0]        o_covariance,
    output logic [GAIN_FRAC_BITS:0]  o_gain
);

    localparam int KW = GAIN_FRAC_BITS + 1;
    localparam int CW = $clog2(KW);
    localparam int PW = DATA_W + 1 + KW;
    localparam logic [KW-1:0] ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [PW:0]   HALF = (PW+1)'(1) << (GAIN_FRAC_BITS - 1);

    logic                 r_primed;
    logic [DATA_W-1:0]    r_sample;
    logic [DATA_W-1:0]    r_est;
    logic [DATA_W-1:0]    r_cov;
    logic [DATA_W-1:0]    r_pp;
    logic [DATA_W:0]      r_mag;
    logic                 r_neg;
    logic [DATA_W:0]      r_den;
    logic                 r_den_zero;
    logic [DATA_W+1:0]    r_rem;
    logic [KW-1:0]        r_q;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_prod;
    logic [DATA_W:0]      r_step;

    logic [DATA_W:0]      pq_sum;
    logic [DATA_W-1:0]    pp_sat;
    logic [DATA_W:0]      resid;
    logic [DATA_W:0]      mag;
    logic [DATA_W:0]      den;
    logic                 rem_ge;
    logic [DATA_W+1:0]    rem_diff;
    logic                 q_bit;
    logic [DATA_W+1:0]    rem_sel;
    logic [DATA_W:0]      mul_a;
    logic [KW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    logic [PW:0]          rnd_sum;
    logic [DATA_W:0]      rnd_hi;
    logic [DATA_W:0]      est_next;

    assign pq_sum   = {1'b0, r_cov} + {1'b0, i_process_noise};
    assign pp_sat   = pq_sum[DATA_W] ? '1 : pq_sum[DATA_W-1:0];
    assign resid    = {r_sample[DATA_W-1], r_sample} - {r_est[DATA_W-1], r_est};
    assign mag      = resid[DATA_W] ? ((DATA_W+1)'(0) - resid) : resid;
    assign den      = {1'b0, r_pp} + {1'b0, i_measurement_noise};

    assign rem_ge   = r_rem >= {1'b0, r_den};
    assign rem_diff = r_rem - {1'b0, r_den};
    assign q_bit    = rem_ge && !r_den_zero;
    assign rem_sel  = q_bit ? rem_diff : r_rem;

    assign mul_a    = i_cmd.mul_est ? r_mag : {1'b0, r_pp};
    assign mul_b    = i_cmd.mul_est ? r_q : (ONE - r_q);
    assign mul_p    = PW'(mul_a) * PW'(mul_b);

    assign rnd_sum  = {1'b0, r_prod} + HALF;
    assign rnd_hi   = rnd_sum[GAIN_FRAC_BITS +: (DATA_W+1)];
    assign est_next = r_neg ? ({r_est[DATA_W-1], r_est} - r_step)
                            : ({r_est[DATA_W-1], r_est} + r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_est    <= '0;
            r_cov    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_primed <= 1'b1;
                if (i_restart || !r_primed) begin
                    r_est <= i_sample;
                    r_cov <= i_start_covariance;
                end
            end
            if (i_cmd.upd) begin
                r_est <= est_next[DATA_W-1:0];
                r_cov <= rnd_hi[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.pred) begin
            r_pp  <= pp_sat;
            r_mag <= mag;
            r_neg <= resid[DATA_W];
        end
        if (i_cmd.init) begin
            r_den      <= den;
            r_den_zero <= (den == '0);
            r_rem      <= {1'b0, 1'b0, r_pp};
            r_q        <= '0;
            r_cnt      <= CW'(GAIN_FRAC_BITS);
        end
        if (i_cmd.div_step) begin
            r_rem <= {rem_sel[DATA_W:0], 1'b0};
            r_q   <= {r_q[KW-2:0], q_bit};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.mul_est) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_cov) begin
            r_step <= rnd_hi;
            r_prod <= mul_p;
        end
    end

    assign o_sts.div_done = (r_cnt == '0);
    assign o_estimate     = r_est;
    assign o_covariance   = r_cov;
    assign o_gain         = r_q;

`ifndef SYNTH
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_cmd.div_step) |-> (r_q <= ONE))
        else $error("gain above one after division");

    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> (r_cov <= r_pp))
        else $error("updated covariance exceeds predicted covariance");
`endif

endmodule

### hw/rtl/skf_ctrl.sv
// Controller state machine of the scalar Kalman filter.
module skf_ctrl import skf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_load,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_PRED;
            ST_PRED:    n_state = ST_INIT;
            ST_INIT:    n_state = ST_DIV;
            ST_DIV:     if (i_sts.div_done) n_state = ST_MUL_EST;
            ST_MUL_EST: n_state = ST_MUL_COV;
            ST_MUL_COV: n_state = ST_UPD;
            ST_UPD:     n_state = ST_WB;
            ST_WB:      if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        o_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_PRED:    o_cmd.pred     = 1'b1;
            ST_INIT:    o_cmd.init     = 1'b1;
            ST_DIV:     o_cmd.div_step = 1'b1;
            ST_MUL_EST: o_cmd.mul_est  = 1'b1;
            ST_MUL_COV: o_cmd.mul_cov  = 1'b1;
            ST_UPD:     o_cmd.upd      = 1'b1;
            ST_WB:      o_out_load     = i_out_free;
            default:    o_in_stall     = 1'b1;
        endcase
    end

endmodule

### hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: config registers, output register, controller and datapath.
// Requests are taken one at a time: a new one is accepted only after the last result is loaded.
// The bit-serial gain divider retires one quotient bit per cycle.
// A finished result waits in the output register while the next request is accepted.
// Reset (i_rst_n low, synchronous): config registers return to defaults, the output empties,
// and the first request after reset restarts the filter from its sample.
module scalar_kalman_filter import skf_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_restart,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_estimate,
    output logic [DATA_W-1:0]        o_covariance,
    output logic [GAIN_W-1:0]        o_gain,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    logic [DATA_W-1:0]       r_process_noise;
    logic [DATA_W-1:0]       r_measurement_noise;
    logic [DATA_W-1:0]       r_start_covariance;
    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_estimate;
    logic [DATA_W-1:0]       r_covariance;
    logic [GAIN_W-1:0]       r_gain;

    t_dp_cmd                 cmd;
    t_dp_sts                 sts;
    logic                    out_free;
    logic                    out_load;
    logic [DATA_W-1:0]       dp_estimate;
    logic [DATA_W-1:0]       dp_covariance;
    logic [GAIN_FRAC_BITS:0] dp_gain;
    logic [DATA_W-1:0]       gain_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise     <= PROCESS_NOISE_RST;
            r_measurement_noise <= MEASUREMENT_NOISE_RST;
            r_start_covariance  <= START_COVARIANCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:     r_process_noise     <= i_cfg_data;
                CFG_MEASUREMENT_NOISE: r_measurement_noise <= i_cfg_data;
                CFG_START_COVARIANCE:  r_start_covariance  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    skf_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_sample            (i_sample),
        .i_restart           (i_restart),
        .i_process_noise     (r_process_noise),
        .i_measurement_noise (r_measurement_noise),
        .i_start_covariance  (r_start_covariance),
        .o_estimate          (dp_estimate),
        .o_covariance        (dp_covariance),
        .o_gain              (dp_gain)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign gain_ext = DATA_W'(dp_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_estimate   <= dp_estimate;
            r_covariance <= dp_covariance;
            r_gain       <= gain_ext[GAIN_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_estimate   = $signed(r_estimate);
    assign o_covariance = r_covariance;
    assign o_gain       = r_gain;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("stalled result overwritten");
`endif

endmodule

### tb/tb_scalar_kalman_filter.sv
// Self-checking testbench for the scalar Kalman filter: directed table, then random phases.
module tb_scalar_kalman_filter;
    import skf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = GAIN_FRAC_BITS_DEF + 16;
    localparam int RANDOM_PHASES = 7;
    localparam int READINGS_PER_PHASE = 100;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [DATA_W-1:0]        covariance;
        logic [GAIN_W-1:0]        gain;
    } t_filter_out;

    typedef enum logic {ROW_WRITE, ROW_READING} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [DATA_W-1:0]    word;
        logic                 restart;
        logic                 known;
        t_filter_out          want;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic                     i_restart = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_estimate;
    logic [DATA_W-1:0]        o_covariance;
    logic [GAIN_W-1:0]        o_gain;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    // filter state tracked alongside the block
    logic [DATA_W-1:0] est_q;
    logic [DATA_W-1:0] cov_q;
    logic              primed_q;
    logic [DATA_W-1:0] q_noise;
    logic [DATA_W-1:0] r_noise;
    logic [DATA_W-1:0] p_start;

    t_filter_out predicted_outputs[$];
    t_row        plan[$];
    int          mismatch_cnt = 0;
    int          hold_left = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;

    scalar_kalman_filter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_estimate   (o_estimate),
        .o_covariance (o_covariance),
        .o_gain       (o_gain),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_filter_out track_measurement(input logic [DATA_W-1:0] meas,
                                                      input logic rs);
        logic [63:0]        unity;
        logic [63:0]        half;
        logic [63:0]        pp;
        logic [63:0]        den;
        logic [63:0]        k;
        logic [63:0]        mag;
        logic [63:0]        step;
        logic [63:0]        pn;
        logic signed [63:0] est;
        logic signed [63:0] resid;
        t_filter_out        res;
        unity = 64'd1 << GAIN_FRAC_BITS_DEF;
        half  = unity >> 1;
        if (rs || !primed_q) begin
            est_q = meas;
            cov_q = p_start;
        end
        primed_q = 1'b1;
        pp = {32'd0, cov_q} + {32'd0, q_noise};
        if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
        den = pp + {32'd0, r_noise};
        k = (den == 64'd0) ? 64'd0 : (pp << GAIN_FRAC_BITS_DEF) / den;
        if (k > unity) k = unity;
        est   = {{32{est_q[31]}}, est_q};
        resid = $signed({{32{meas[31]}}, meas}) - est;
        mag   = resid[63] ? -resid : resid;
        step  = (mag * k + half) >> GAIN_FRAC_BITS_DEF;
        est   = resid[63] ? est - $signed(step) : est + $signed(step);
        est_q = est[DATA_W-1:0];
        pn = ((unity - k) * pp + half) >> GAIN_FRAC_BITS_DEF;
        if (pn > 64'hFFFF_FFFF) pn = 64'hFFFF_FFFF;
        cov_q = pn[DATA_W-1:0];
        res.estimate   = est_q;
        res.covariance = cov_q;
        res.gain       = k[GAIN_W-1:0];
        return res;
    endfunction

    // mostly short idles, a few long ones
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 20);
        return $urandom_range(21, 80);
    endfunction

    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return $urandom_range(0, 32'h0100_0000);
            6, 7:       return $urandom_range(0, 32'h1000_0000);
            default:    return $urandom;
        endcase
    endfunction

    task automatic add_write(input logic [CFG_IDX_W-1:0] sel, input logic [DATA_W-1:0] val);
        t_row row;
        row = '0;
        row.kind    = ROW_WRITE;
        row.reg_sel = sel;
        row.word    = val;
        plan.push_back(row);
    endtask

    task automatic add_reading(input logic [DATA_W-1:0] meas, input logic rs);
        t_row row;
        row = '0;
        row.kind    = ROW_READING;
        row.word    = meas;
        row.restart = rs;
        plan.push_back(row);
    endtask

    task automatic add_known(input logic [DATA_W-1:0] meas, input logic rs,
                             input logic [DATA_W-1:0] est, input logic [DATA_W-1:0] cov,
                             input logic [GAIN_W-1:0] gain);
        t_row row;
        row = '0;
        row.kind                = ROW_READING;
        row.word                = meas;
        row.restart             = rs;
        row.known               = 1'b1;
        row.want.estimate       = est;
        row.want.covariance     = cov;
        row.want.gain           = gain;
        plan.push_back(row);
    endtask

    // registers change only with the filter drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (sel)
            CFG_PROCESS_NOISE:     q_noise = val;
            CFG_MEASUREMENT_NOISE: r_noise = val;
            CFG_START_COVARIANCE:  p_start = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_reading(input logic [DATA_W-1:0] meas, input logic rs,
                                input logic known, input t_filter_out typed);
        int          gap;
        t_filter_out model;
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample   <= meas;
        i_restart  <= rs;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model = track_measurement(meas, rs);
        predicted_outputs.push_back(known ? typed : model);
    endtask

    always @(posedge i_clk) begin : result_check
        t_filter_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_outputs.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: estimate %h covariance %h gain %h",
                                 o_estimate, o_covariance, o_gain);
                    mismatch_cnt++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (o_estimate !== want.estimate || o_covariance !== want.covariance ||
                        o_gain !== want.gain) begin
                        if (mismatch_cnt < 10)
                            $display("result mismatch (exp/act): estimate %h/%h %s %h/%h %s %h/%h",
                                     want.estimate, o_estimate, "covariance",
                                     want.covariance, o_covariance, "gain",
                                     want.gain, o_gain);
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                hold_left = pick_gap(out_quiet);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int                level;
        int                sel;
        logic [DATA_W-1:0] reading;
        logic              rs;

        q_noise  = PROCESS_NOISE_RST;
        r_noise  = MEASUREMENT_NOISE_RST;
        p_start  = START_COVARIANCE_RST;
        est_q    = '0;
        cov_q    = '0;
        primed_q = 1'b0;

        // default registers; first request restarts on its own
        add_reading(32'h7FFF_FFFF, 1'b0);
        add_reading(32'h8000_0000, 1'b0);
        add_reading(32'h8000_0000, 1'b1);
        add_reading(32'h7FFF_FFFF, 1'b0);
        add_reading(32'h0000_0000, 1'b0);
        add_reading(32'h0001_0000, 1'b0);
        add_reading(32'hFFFF_0000, 1'b1);
        // zero denominator; spare index must not land anywhere
        add_write(CFG_PROCESS_NOISE, 32'h0);
        add_write(CFG_MEASUREMENT_NOISE, 32'h0);
        add_write(CFG_START_COVARIANCE, 32'h0);
        add_write(CFG_SPARE, 32'hFFFF_FFFF);
        add_known(32'h1234_5678, 1'b1, 32'h1234_5678, 32'h0, 25'h0);
        add_known(32'h8000_0000, 1'b0, 32'h1234_5678, 32'h0, 25'h0);
        // full gain from max covariance, then zero denominator
        add_write(CFG_START_COVARIANCE, 32'hFFFF_FFFF);
        add_known(32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, 32'h0, 25'h100_0000);
        add_known(32'h0000_0001, 1'b0, 32'hDEAD_BEEF, 32'h0, 25'h0);
        // saturated prediction, half gain
        add_write(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
        add_write(CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        add_known(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 25'h80_0000);
        add_known(32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 25'h80_0000);
        // saturated prediction, no measurement noise
        add_write(CFG_MEASUREMENT_NOISE, 32'h0);
        add_known(32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0, 25'h100_0000);
        add_known(32'h4000_0000, 1'b0, 32'h4000_0000, 32'h0, 25'h100_0000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_register(plan[i].reg_sel, plan[i].word);
            else
                send_reading(plan[i].word, plan[i].restart, plan[i].known, plan[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            in_quiet  = (ph == 3);
            out_quiet = (ph == 3) || (ph == 5);
            if (ph == 0) begin
                write_register(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
                write_register(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
                write_register(CFG_START_COVARIANCE, START_COVARIANCE_RST);
            end else begin
                write_register(CFG_PROCESS_NOISE, pick_noise());
                write_register(CFG_MEASUREMENT_NOISE, pick_noise());
                write_register(CFG_START_COVARIANCE, pick_noise());
            end
            if ($urandom_range(0, 2) == 0) write_register(CFG_SPARE, $urandom);
            level = int'($urandom) >>> 1;
            for (int n = 0; n < READINGS_PER_PHASE; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 4) level = int'($urandom) >>> 1;
                if (sel < 80)
                    reading = level + int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
                else if (sel < 94)
                    reading = $urandom;
                else
                    reading = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                rs = ($urandom_range(0, 99) < 5);
                send_reading(reading, rs, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hw/rtl/skf_pkg.sv
hw/rtl/skf_dp.sv
hw/rtl/skf_ctrl.sv
hw/rtl/scalar_kalman_filter.sv
tb/tb_scalar_kalman_filter.sv
